FILE: rtl/core/mtk_pkg.sv
package mtk_pkg;

  typedef enum logic {
    OP_KEY    = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CASE_LOWER = 2'd0,
    CASE_UPPER = 2'd1,
    CASE_SMART = 2'd2,
    CASE_KEEP  = 2'd3
  } case_mode_t;

  localparam logic [1:0] CFG_CASE_MODE = 2'd0;
  localparam logic [1:0] CFG_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_DEL_GAP   = 2'd2;

  localparam logic [3:0]  NO_KEY      = 4'd10;
  localparam logic [3:0]  LAST_KEY    = 4'd9;
  localparam logic [15:0] WINDOW_RST  = 16'd1000;
  localparam logic [15:0] DEL_GAP_RST = 16'd200;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_EXCL  = 7'h21;
  localparam logic [6:0] CH_QUES  = 7'h3f;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_LO_A  = 7'h61;
  localparam logic [6:0] CH_LO_Z  = 7'h7a;
  localparam logic [6:0] CH_UP_A  = 7'h41;
  localparam logic [6:0] CH_UP_Z  = 7'h5a;
  localparam logic [6:0] CASE_OFS = 7'h20;

  // symbol string length per key
  function automatic logic [2:0] sym_len(input logic [3:0] key);
    logic [2:0] n;
    case (key)
      4'd0:                 n = 3'd2;
      4'd1, 4'd7, 4'd9:     n = 3'd5;
      default:              n = 3'd4;
    endcase
    return n;
  endfunction

  // character of a key's symbol string at a given slot
  function automatic logic [6:0] sym_char(input logic [3:0] key, input logic [2:0] slot);
    logic [7:0] c;
    c = " ";
    case (key)
      4'd0: c = (slot == 3'd0) ? " " : "0";
      4'd1: case (slot)
              3'd0: c = ".";  3'd1: c = ",";  3'd2: c = "?";  3'd3: c = "!";
              default: c = "1";
            endcase
      4'd2: case (slot)
              3'd0: c = "a";  3'd1: c = "b";  3'd2: c = "c";  default: c = "2";
            endcase
      4'd3: case (slot)
              3'd0: c = "d";  3'd1: c = "e";  3'd2: c = "f";  default: c = "3";
            endcase
      4'd4: case (slot)
              3'd0: c = "g";  3'd1: c = "h";  3'd2: c = "i";  default: c = "4";
            endcase
      4'd5: case (slot)
              3'd0: c = "j";  3'd1: c = "k";  3'd2: c = "l";  default: c = "5";
            endcase
      4'd6: case (slot)
              3'd0: c = "m";  3'd1: c = "n";  3'd2: c = "o";  default: c = "6";
            endcase
      4'd7: case (slot)
              3'd0: c = "p";  3'd1: c = "q";  3'd2: c = "r";  3'd3: c = "s";
              default: c = "7";
            endcase
      4'd8: case (slot)
              3'd0: c = "t";  3'd1: c = "u";  3'd2: c = "v";  default: c = "8";
            endcase
      4'd9: case (slot)
              3'd0: c = "w";  3'd1: c = "x";  3'd2: c = "y";  3'd3: c = "z";
              default: c = "9";
            endcase
      default: c = " ";
    endcase
    return c[6:0];
  endfunction

  typedef struct packed {
    logic [3:0] key;
    logic [2:0] slot;
    logic       cycle;
    logic [7:0] pos;
    logic [6:0] back_one;
    logic [6:0] back_two;
    logic [6:0] back_three;
    case_mode_t case_mode;
  } dec_req_t;

  typedef struct packed {
    logic [6:0] code;
    logic [7:0] pos;
  } dec_res_t;

endpackage

FILE: rtl/core/mtk_decode.sv
module mtk_decode import mtk_pkg::*; (
  input  dec_req_t req,
  output dec_res_t res
);

  logic [6:0] ch;
  logic [6:0] ch_up;
  logic [6:0] ch_low;
  logic [6:0] prev;
  logic [6:0] prevprev;
  logic [7:0] pos;
  logic       is_digit;
  logic       end_mark;
  logic       step_back;

  assign ch        = sym_char(req.key, req.slot);
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign ch_up     = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ? ch - CASE_OFS : ch;
  assign ch_low    = ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) ? ch + CASE_OFS : ch;

  // a cycling press overwrites the previous character unless already at the start
  assign step_back = req.cycle && (req.pos != 8'd0);
  assign pos       = step_back ? req.pos - 8'd1 : req.pos;
  assign prev      = step_back ? req.back_two : req.back_one;
  assign prevprev  = step_back ? req.back_three : req.back_two;
  assign end_mark  = (prevprev == CH_DOT) || (prevprev == CH_EXCL) || (prevprev == CH_QUES);

  always_comb begin
    res.pos  = pos;
    res.code = ch;
    unique case (req.case_mode)
      CASE_SMART: begin
        if (!is_digit) begin
          if (pos == 8'd0) res.code = ch_up;
          else if (pos >= 8'd2 && prev == CH_SPACE && end_mark) res.code = ch_up;
          else res.code = ch_low;
        end
      end
      CASE_UPPER: begin
        if (!is_digit) res.code = ch_up;
      end
      default: res.code = ch;
    endcase
  end

endmodule

FILE: rtl/core/multitap_key_to_char.sv
// multitap keypad decoder
// input channel: one word per key press or delete request, with a millisecond
// timestamp and the three characters before the current write position
// output channel: one result word per input word (character, overwrite flag,
// write position, delete flag); a digit above nine yields an all-zero result
// configuration: cfg_write with cfg_index 0 case mode, 1 multitap window,
// 2 delete gap; writes to index 3 are dropped
// each input word is loaded into the input register on acceptance and then into
// the result register, which drives the outputs
// throughput: one word per cycle while the receiver does not stall
// multitap and delete state is updated as each word leaves the input register,
// so back-to-back presses see each other's effect
// when out_stall is high the result register holds, the input register fills
// and in_stall rises only once both are occupied
// reset (rst_n low at a clock edge): no key remembered, times cleared, case mode
// smart, window 1000 ms, delete gap 200 ms, both registers empty
module multitap_key_to_char import mtk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [3:0]  in_key_digit,
  input  logic [31:0] in_timestamp,
  input  logic [7:0]  in_buffer_position,
  input  logic [6:0]  in_char_back_one,
  input  logic [6:0]  in_char_back_two,
  input  logic [6:0]  in_char_back_three,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_char_valid,
  output logic [6:0]  out_char_code,
  output logic        out_replaces_previous,
  output logic [7:0]  out_write_position,
  output logic        out_delete_accepted
);

  case_mode_t  case_mode_r;
  logic [15:0] window_r;
  logic [15:0] del_gap_r;

  logic [3:0]  prev_key_r;
  logic [2:0]  slot_r;
  logic [31:0] press_time_r;
  logic [31:0] del_time_r;

  // input register
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [3:0]  s1_key_r;
  logic [31:0] s1_time_r;
  logic [7:0]  s1_pos_r;
  logic [6:0]  s1_b1_r;
  logic [6:0]  s1_b2_r;
  logic [6:0]  s1_b3_r;

  // result register
  logic        out_valid_r;
  logic        out_char_valid_r;
  logic [6:0]  out_code_r;
  logic        out_repl_r;
  logic [7:0]  out_pos_r;
  logic        out_del_r;

  logic        in_acc;
  logic        adv;
  logic        fire;
  logic [31:0] press_diff;
  logic [31:0] del_diff;
  logic        cycle;
  logic        key_ok;
  logic        del_ok;
  logic [2:0]  slot_inc;
  logic [2:0]  slot_nxt;
  dec_req_t    dreq;
  dec_res_t    dres;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = s1_valid_r && adv;

  assign press_diff = s1_time_r - press_time_r;
  assign del_diff   = s1_time_r - del_time_r;
  assign key_ok     = (s1_key_r <= LAST_KEY);
  assign del_ok     = del_diff > {16'd0, del_gap_r};
  assign cycle      = (s1_key_r == prev_key_r) && (press_diff < {16'd0, window_r});
  assign slot_inc   = slot_r + 3'd1;
  assign slot_nxt   = !cycle ? 3'd0 : (slot_inc >= sym_len(s1_key_r)) ? 3'd0 : slot_inc;

  always_comb begin
    dreq.key        = s1_key_r;
    dreq.slot       = slot_nxt;
    dreq.cycle      = cycle;
    dreq.pos        = s1_pos_r;
    dreq.back_one   = s1_b1_r;
    dreq.back_two   = s1_b2_r;
    dreq.back_three = s1_b3_r;
    dreq.case_mode  = case_mode_r;
  end

  mtk_decode u_decode (
    .req (dreq),
    .res (dres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_mode_r <= CASE_SMART;
      window_r    <= WINDOW_RST;
      del_gap_r   <= DEL_GAP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CASE_MODE: case_mode_r <= case_mode_t'(cfg_data[1:0]);
        CFG_WINDOW:    window_r    <= cfg_data;
        CFG_DEL_GAP:   del_gap_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_t'(in_operation);
      s1_key_r  <= in_key_digit;
      s1_time_r <= in_timestamp;
      s1_pos_r  <= in_buffer_position;
      s1_b1_r   <= in_char_back_one;
      s1_b2_r   <= in_char_back_two;
      s1_b3_r   <= in_char_back_three;
    end
  end

  // multitap and delete state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_r   <= NO_KEY;
      slot_r       <= 3'd0;
      press_time_r <= 32'd0;
      del_time_r   <= 32'd0;
    end else if (fire) begin
      if (s1_op_r == OP_DELETE) begin
        if (del_ok) begin
          prev_key_r <= NO_KEY;
          slot_r     <= 3'd0;
          del_time_r <= s1_time_r;
        end
      end else if (key_ok) begin
        prev_key_r   <= s1_key_r;
        slot_r       <= slot_nxt;
        press_time_r <= s1_time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char_valid_r <= 1'b0;
      out_code_r       <= 7'd0;
      out_repl_r       <= 1'b0;
      out_pos_r        <= 8'd0;
      out_del_r        <= 1'b0;
      if (s1_op_r == OP_DELETE) begin
        out_del_r <= del_ok;
      end else if (key_ok) begin
        out_char_valid_r <= 1'b1;
        out_code_r       <= dres.code;
        out_repl_r       <= cycle;
        out_pos_r        <= dres.pos;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_char_valid        = out_char_valid_r;
  assign out_char_code         = out_code_r;
  assign out_replaces_previous = out_repl_r;
  assign out_write_position    = out_pos_r;
  assign out_delete_accepted   = out_del_r;

endmodule
